[rtl/core/sse_pkg.sv]
// ----------------------------------------------------------------------------
// sse_pkg
// Shared constants, types and the prefix table of the sse data extractor.
// ----------------------------------------------------------------------------
package sse_pkg;

   localparam int BYTE_W = 8;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [2:0]        phase_type;

   // line phase codes: 0..4 count matched prefix bytes
   localparam phase_type PHASE_START  = 3'd0;
   localparam phase_type PHASE_LAST_P = 3'd4;
   localparam phase_type PHASE_VALUE  = 3'd5;
   localparam phase_type PHASE_IGNORE = 3'd6;

   localparam byte_type LINE_FEED  = 8'h0A;
   localparam byte_type SPACE_BYTE = 8'h20;

   typedef struct packed {
      logic     valid;
      byte_type out_byte;
      logic     event_end;
   } result_type;

   // "data:" by position
   function automatic byte_type prefix_char(input phase_type idx);
      byte_type c;
      unique case (idx)
         3'd0:    c = 8'h64;
         3'd1:    c = 8'h61;
         3'd2:    c = 8'h74;
         3'd3:    c = 8'h61;
         3'd4:    c = 8'h3A;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

[rtl/core/sse_channels.sv]
// ----------------------------------------------------------------------------
// sse channel interfaces
// Valid/ready channels for the byte input and the extracted data output.
// ----------------------------------------------------------------------------
interface sse_req_if
   import sse_pkg::*;
();
   logic     valid;
   logic     ready;
   byte_type in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface sse_rsp_if
   import sse_pkg::*;
();
   logic     valid;
   logic     ready;
   byte_type out_byte;
   logic     event_end;

   modport source (output valid, output out_byte, output event_end, input ready);
   modport sink   (input valid, input out_byte, input event_end, output ready);
endinterface

[rtl/core/sse_in_reg.sv]
// ----------------------------------------------------------------------------
// sse_in_reg
// Input register: holds one byte until the parser consumes it.
// ----------------------------------------------------------------------------
module sse_in_reg
   import sse_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  byte_type req_byte,
   input  logic     advance,
   output logic     hold_valid,
   output byte_type hold_byte
);

   logic     valid_ff, valid_in;
   byte_type byte_ff, byte_in;

   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         byte_in  = req_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign hold_valid = valid_ff;
   assign hold_byte  = byte_ff;

endmodule

[rtl/core/sse_parser.sv]
// ----------------------------------------------------------------------------
// sse_line_tracker
// Line and prefix tracking; decides per byte whether a transaction results.
// ----------------------------------------------------------------------------
module sse_line_tracker
   import sse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  byte_type   in_byte,
   output result_type result
);

   phase_type phase_ff, phase_in;
   logic      first_ff, first_in;
   logic      lastlf_ff, lastlf_in;
   logic      has_ff, has_in;

   always_comb begin
      phase_in         = phase_ff;
      first_in         = first_ff;
      lastlf_in        = lastlf_ff;
      has_in           = has_ff;
      result.valid     = 1'b0;
      result.out_byte  = in_byte;
      result.event_end = 1'b0;
      if (in_byte == LINE_FEED) begin
         phase_in = PHASE_START;
         first_in = 1'b0;
         if (lastlf_ff) begin
            // second line feed of a pair closes the event
            lastlf_in        = 1'b0;
            has_in           = 1'b0;
            result.valid     = has_ff;
            result.out_byte  = '0;
            result.event_end = 1'b1;
         end else begin
            lastlf_in = 1'b1;
         end
      end else begin
         lastlf_in = 1'b0;
         if (phase_ff < PHASE_VALUE) begin
            if (in_byte == prefix_char(phase_ff)) begin
               phase_in = phase_ff + 3'd1;
               if (phase_ff == PHASE_LAST_P) begin
                  first_in = 1'b1;
               end
            end else begin
               phase_in = PHASE_IGNORE;
            end
         end else if (phase_ff == PHASE_VALUE) begin
            first_in = 1'b0;
            // one space right after the prefix is dropped
            if (!(first_ff && in_byte == SPACE_BYTE)) begin
               has_in       = 1'b1;
               result.valid = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_START;
         first_ff  <= 1'b0;
         lastlf_ff <= 1'b0;
         has_ff    <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         first_ff  <= first_in;
         lastlf_ff <= lastlf_in;
         has_ff    <= has_in;
      end
   end

endmodule

[rtl/core/sse_out_reg.sv]
// ----------------------------------------------------------------------------
// sse_out_reg
// Result register in front of the output channel.
// ----------------------------------------------------------------------------
module sse_out_reg
   import sse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   output logic       can_take,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output byte_type   rsp_byte,
   output logic       rsp_end
);

   logic     valid_ff, valid_in;
   byte_type byte_ff, byte_in;
   logic     end_ff, end_in;

   assign can_take = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      if (load) begin
         valid_in = result.valid;
         byte_in  = result.out_byte;
         end_in   = result.event_end;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      end_ff  <= end_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_byte  = byte_ff;
   assign rsp_end   = end_ff;

endmodule

[rtl/core/sse_data_field_extractor.sv]
// ----------------------------------------------------------------------------
// sse_data_field_extractor
// Pulls the value bytes of "data:" lines out of an event-stream byte stream.
//
// req_ch carries one stream byte per transaction (in_byte). rsp_ch carries
// a value byte (event_end low) or an end-of-event marker (event_end high,
// out_byte zero) after a blank line that closes an event with data.
// Bytes that start no result (prefix, ignored lines, line feeds, the
// space after the prefix) are consumed without a response transaction.
// Throughput: one byte per cycle while the result register can take one,
// set by the single parser step between the input register and the result
// register. An accepted byte is held in the input register and moves into
// the result register, which drives rsp_ch valid, once that one is free.
// Reset clears both registers' valid flags and the line state; the block
// then starts at the beginning of a line with an empty event.
// When the receiver stalls, the result register holds its transaction and
// the input register keeps one byte; req_ch.ready drops once both are full
// and rises again in the cycle the result is taken.
// ----------------------------------------------------------------------------
module sse_data_field_extractor
   import sse_pkg::*;
(
   input logic        clock,
   input logic        reset,
   sse_req_if.sink    req_ch,
   sse_rsp_if.source  rsp_ch
);

   logic       hold_valid;
   byte_type   hold_byte;
   logic       can_take;
   logic       advance;
   result_type result;

   assign advance = hold_valid && can_take;

   sse_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_byte   (req_ch.in_byte),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_byte  (hold_byte)
   );

   sse_line_tracker u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_byte (hold_byte),
      .result  (result)
   );

   sse_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result    (result),
      .can_take  (can_take),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_byte  (rsp_ch.out_byte),
      .rsp_end   (rsp_ch.event_end)
   );

endmodule
